// ----- rtl/core/srtp_pkg.sv -----
// Package with shared types and constants of the SRTP replay and ROC check block.
`default_nettype none

package srtp_pkg;

  // Default depth of the anti-replay bitmap in packets.
  localparam int unsigned WINDOW_SIZE_DEF = 64;

  // RTP fixed header facts.
  localparam logic [1:0] RTP_VERSION    = 2'd2;
  localparam int unsigned HDR_FIXED_LEN = 12;
  localparam int unsigned EXT_HDR_LEN   = 4;

  // Offset width: 12 + 4*15 + 4 + 4*65535 needs 19 bits.
  localparam int unsigned OFFSET_W = 19;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_REPLAY    = 2'd2;

  // Outcome of the header parse.
  typedef struct packed {
    logic        malformed;
    logic [15:0] offset;
  } hdr_res_t;

  // Outcome of the replay check and ROC estimate.
  typedef struct packed {
    logic        rejected;
    logic [31:0] roc;
  } rpl_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/srtp_hdr_chk.sv -----
// Header check and payload offset computation for one RTP header.
`default_nettype none

module srtp_hdr_chk (
  input  wire logic [7:0]      first_byte,
  input  wire logic [15:0]     ext_words,
  input  wire logic [15:0]     packet_len,
  output srtp_pkg::hdr_res_t   res
);

  logic [srtp_pkg::OFFSET_W-1:0] base_off;
  logic [srtp_pkg::OFFSET_W-1:0] full_off;
  logic                          ext_flag;
  logic                          bad_ver;

  assign ext_flag = first_byte[4];
  assign bad_ver  = (first_byte[7:6] != srtp_pkg::RTP_VERSION);

  // The fixed header plus the CSRC list, then the extension header and its body.
  assign base_off = srtp_pkg::OFFSET_W'(srtp_pkg::HDR_FIXED_LEN)
                  + {{(srtp_pkg::OFFSET_W-6){1'b0}}, first_byte[3:0], 2'b00};
  assign full_off = ext_flag
                  ? base_off + srtp_pkg::OFFSET_W'(srtp_pkg::EXT_HDR_LEN)
                    + {1'b0, ext_words, 2'b00}
                  : base_off;

  // The final offset never falls below the earlier limits, so one compare covers all
  // the length checks.
  always_comb begin
    res.malformed = bad_ver || ({3'b000, packet_len} < full_off);
    res.offset    = full_off[15:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/srtp_replay.sv -----
// Rollover count estimate and anti-replay bitmap with its state registers.
`default_nettype none

module srtp_replay #(
  parameter int unsigned WINDOW_SIZE = srtp_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          upd_en,
  input  wire logic [15:0]   seq_number,
  output srtp_pkg::rpl_res_t res
);

  localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);

  logic [15:0]            highest_seq_r, highest_seq_nxt;
  logic [31:0]            roc_r, roc_nxt;
  logic [WINDOW_SIZE-1:0] win_r, win_nxt;

  logic [15:0]            seq_delta;
  logic [15:0]            lag;
  logic                   ahead;
  logic                   in_win;
  logic                   bit_seen;
  logic [31:0]            roc_est;
  logic [WINDOW_SIZE-1:0] win_shifted;

  assign seq_delta = seq_number - highest_seq_r;
  assign lag       = highest_seq_r - seq_number;
  assign ahead     = (seq_delta != 16'd0) && !seq_delta[15];

  always_comb begin
    roc_est = roc_r;
    if (!seq_delta[15]) begin
      if (seq_number < highest_seq_r) roc_est = roc_r + 32'd1;
    end else begin
      if (seq_number > highest_seq_r) roc_est = roc_r - 32'd1;
    end
  end

  assign in_win   = ({16'd0, lag} < 32'(WINDOW_SIZE));
  assign bit_seen = in_win && win_r[lag[IDX_W-1:0]];

  assign win_shifted = ({16'd0, seq_delta} >= 32'(WINDOW_SIZE))
                     ? '0 : (win_r << seq_delta[IDX_W-1:0]);

  always_comb begin
    res.rejected = !ahead && (!in_win || bit_seen);
    res.roc      = roc_est;
  end

  always_comb begin
    highest_seq_nxt = highest_seq_r;
    roc_nxt         = roc_r;
    win_nxt         = win_r;
    if (upd_en && !res.rejected) begin
      if (ahead) begin
        win_nxt         = win_shifted | WINDOW_SIZE'(1);
        highest_seq_nxt = seq_number;
        roc_nxt         = roc_est;
      end else begin
        win_nxt[lag[IDX_W-1:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_seq_r <= '0;
      roc_r         <= '0;
      win_r         <= '0;
    end else begin
      highest_seq_r <= highest_seq_nxt;
      roc_r         <= roc_nxt;
      win_r         <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srtp_rtp_replay_and_roc_check.sv -----
// Top level of the SRTP receive header check, ROC estimate and replay filter.
//
// One input transaction carries the first header byte, the sequence number, the
// extension length in 32-bit words and the packet length. One output transaction
// returns a status (accepted, malformed header, or replayed / outside the window),
// the payload byte offset and the estimated rollover count for that packet.
// Both channels use valid and stall; a transaction moves on a rising edge with
// valid high and stall low.
// An accepted input is loaded into the input register; the result register
// loads it when empty or being drained. Throughput is one transaction per cycle
// while the receiver does not stall. The replay state updates at the same edge
// that loads the result, so the following packet already sees it and packets
// can follow back to back.
// When the receiver stalls, the result register holds its transaction and the
// input register holds the next one; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) clears the highest sequence number, the rollover
// count and the whole replay bitmap, and empties both registers.
`default_nettype none

module srtp_rtp_replay_and_roc_check #(
  parameter int unsigned WINDOW_SIZE = srtp_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_first_byte,
  input  wire logic [15:0] in_seq_number,
  input  wire logic [15:0] in_ext_words,
  input  wire logic [15:0] in_packet_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_payload_offset,
  output logic [31:0]      out_packet_roc
);

  // Input register.
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  first_byte_r;
  logic [15:0] seq_number_r;
  logic [15:0] ext_words_r;
  logic [15:0] packet_len_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [31:0] roc_r, roc_nxt;

  logic               advance;
  logic               proc;
  logic               in_take;
  srtp_pkg::hdr_res_t hdr_res;
  srtp_pkg::rpl_res_t rpl_res;

  // The result register can take a new transaction when empty or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  srtp_hdr_chk u_hdr_chk (
    .first_byte (first_byte_r),
    .ext_words  (ext_words_r),
    .packet_len (packet_len_r),
    .res        (hdr_res)
  );

  // Malformed packets must leave the replay state untouched.
  srtp_replay #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_replay (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (proc && !hdr_res.malformed),
    .seq_number (seq_number_r),
    .res        (rpl_res)
  );

  assign in_valid_nxt  = in_stall ? 1'b1 : in_valid;
  assign out_valid_nxt = proc ? 1'b1 : (out_valid_r && out_stall);

  always_comb begin
    if (hdr_res.malformed) begin
      status_nxt = srtp_pkg::STATUS_MALFORMED;
      offset_nxt = '0;
      roc_nxt    = '0;
    end else if (rpl_res.rejected) begin
      status_nxt = srtp_pkg::STATUS_REPLAY;
      offset_nxt = '0;
      roc_nxt    = '0;
    end else begin
      status_nxt = srtp_pkg::STATUS_OK;
      offset_nxt = hdr_res.offset;
      roc_nxt    = rpl_res.roc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      first_byte_r <= in_first_byte;
      seq_number_r <= in_seq_number;
      ext_words_r  <= in_ext_words;
      packet_len_r <= in_packet_len;
    end
    if (proc) begin
      status_r <= status_nxt;
      offset_r <= offset_nxt;
      roc_r    <= roc_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_payload_offset = offset_r;
  assign out_packet_roc     = roc_r;

endmodule

`default_nettype wire

// ----- dv/srtp_replay_checker.sv -----
// Checker that predicts and compares every result of the SRTP replay and ROC check block.
`timescale 1ns / 1ps

module srtp_replay_checker #(
  parameter int unsigned WINDOW_SIZE = srtp_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_first_byte,
  input  wire logic [15:0] in_seq_number,
  input  wire logic [15:0] in_ext_words,
  input  wire logic [15:0] in_packet_len,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_status,
  input  wire logic [15:0] out_payload_offset,
  input  wire logic [31:0] out_packet_roc,
  output int unsigned      n_mismatch,
  output int unsigned      n_pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [31:0] roc;
  } verdict_t;

  verdict_t verdict_q[$];

  // Private copy of the receive state.
  logic [15:0]            top_seq;
  logic [31:0]            roc_count;
  logic [WINDOW_SIZE-1:0] seen_mask;
  int unsigned            n_results;

  initial begin
    n_mismatch = 0;
    n_pending  = 0;
    n_results  = 0;
    top_seq    = '0;
    roc_count  = '0;
    seen_mask  = '0;
  end

  // Works out the verdict for one header and updates the state as the block must.
  task automatic judge_packet(input logic [7:0] fb, input logic [15:0] seq,
                              input logic [15:0] ext, input logic [15:0] len,
                              output verdict_t v);
    int unsigned off;
    logic [15:0] seq_delta;
    logic [15:0] lag;
    logic [31:0] roc_est;
    logic        ahead;
    v = '{srtp_pkg::STATUS_MALFORMED, 16'd0, 32'd0};
    if (len < srtp_pkg::HDR_FIXED_LEN || fb[7:6] != srtp_pkg::RTP_VERSION) return;
    off = srtp_pkg::HDR_FIXED_LEN + 4 * int'(fb[3:0]);
    if (fb[4]) begin
      off += srtp_pkg::EXT_HDR_LEN;
      if (int'(len) < off) return;
      off += 4 * int'(ext);
    end
    if (int'(len) < off) return;

    seq_delta = seq - top_seq;
    roc_est   = roc_count;
    if (!seq_delta[15]) begin
      if (seq < top_seq) roc_est = roc_est + 32'd1;
    end else if (seq > top_seq) begin
      roc_est = roc_est - 32'd1;
    end
    ahead = (seq_delta != 16'd0) && !seq_delta[15];

    if (ahead) begin
      seen_mask    = (seq_delta >= WINDOW_SIZE) ? '0 : (seen_mask << seq_delta);
      seen_mask[0] = 1'b1;
      top_seq      = seq;
      roc_count    = roc_est;
    end else begin
      lag = top_seq - seq;
      if (lag >= WINDOW_SIZE || seen_mask[lag]) begin
        v.status = srtp_pkg::STATUS_REPLAY;
        return;
      end
      seen_mask[lag] = 1'b1;
    end
    v = '{srtp_pkg::STATUS_OK, 16'(off), roc_est};
  endtask

  task automatic flag_bad(input verdict_t want, input verdict_t got, input string why);
    if (n_mismatch < 10) begin
      $display("mismatch on result %0d (%s): status %0d/%0d offset %0d/%0d roc %0h/%0h",
               n_results, why, want.status, got.status, want.offset, got.offset,
               want.roc, got.roc);
    end
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      top_seq   = '0;
      roc_count = '0;
      seen_mask = '0;
      verdict_q.delete();
    end else begin
      // Results are checked before the new input is predicted: each input passes the
      // input and result registers first, so both can never be the same packet.
      if (out_valid && !out_stall) begin
        got = '{out_status, out_payload_offset, out_packet_roc};
        if (verdict_q.size() == 0) begin
          flag_bad('0, got, "nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status || got.offset !== want.offset ||
              got.roc !== want.roc) begin
            flag_bad(want, got, "expected/actual");
          end
        end
        n_results++;
      end
      if (in_valid && !in_stall) begin
        judge_packet(in_first_byte, in_seq_number, in_ext_words, in_packet_len, want);
        verdict_q.push_back(want);
      end
    end
    n_pending = verdict_q.size();
  end

endmodule

// ----- dv/tb_srtp_rtp_replay_and_roc_check.sv -----
// Top of the testbench: clock, reset, header stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module tb_srtp_rtp_replay_and_roc_check;

  // Number of random headers after the directed part.
  localparam int unsigned N_RANDOM   = 1030;
  // Cycles without any transaction after which the run is declared hung.
  // The longest legal quiet stretch is a sender gap overlapping a receiver stall.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Cycles to let pass after the last result.
  localparam int unsigned TAIL_CYCLES = 8;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_first_byte = '0;
  logic [15:0] in_seq_number = '0;
  logic [15:0] in_ext_words  = '0;
  logic [15:0] in_packet_len = '0;
  logic        out_stall     = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_payload_offset;
  logic [31:0] out_packet_roc;

  int unsigned n_mismatch;
  int unsigned n_pending;
  int unsigned idle_cycles = 0;
  // Remaining headers of a back-to-back burst with no sender gaps.
  int unsigned burst_left  = 0;

  always #10 clk = ~clk;

  srtp_rtp_replay_and_roc_check u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_byte      (in_first_byte),
    .in_seq_number      (in_seq_number),
    .in_ext_words       (in_ext_words),
    .in_packet_len      (in_packet_len),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_packet_roc     (out_packet_roc)
  );

  srtp_replay_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_byte      (in_first_byte),
    .in_seq_number      (in_seq_number),
    .in_ext_words       (in_ext_words),
    .in_packet_len      (in_packet_len),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_packet_roc     (out_packet_roc),
    .n_mismatch         (n_mismatch),
    .n_pending          (n_pending)
  );

  // Watchdog. Any cycle in which either channel moves a transaction restarts
  // the count, so the limit only trips when the block has really stopped.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver. It alternates between stalling and taking results, mostly in
  // short runs, with the odd long stall and long free-running stretches so
  // that the block's internal buffering fills and drains at every phase.
  initial begin
    int unsigned pick;
    int unsigned run;
    logic        hold;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        hold = 1'b0;
        run  = $urandom_range(1, 4);
      end else if (pick < 85) begin
        hold = 1'b1;
        run  = $urandom_range(1, 3);
      end else if (pick < 95) begin
        hold = 1'b0;
        run  = $urandom_range(30, 200);
      end else begin
        hold = 1'b1;
        run  = $urandom_range(40, 150);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= hold;
      end
    end
  end

  // Presents one header and holds it until the block takes it. A random gap
  // comes first; valid is only lowered when the gap is not zero, so back-to-back
  // transactions keep valid high without a glitch.
  task automatic send_packet(input logic [7:0] fb, input logic [15:0] seq,
                             input logic [15:0] ext, input logic [15:0] len);
    int unsigned gap;
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        burst_left = $urandom_range(40, 80);
        gap = 0;
      end else if (pick < 58) begin
        gap = 0;
      end else if (pick < 95) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(20, 120);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_first_byte <= fb;
    in_seq_number <= seq;
    in_ext_words  <= ext;
    in_packet_len <= len;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int unsigned i;
    int unsigned pick;
    int unsigned cc;
    int unsigned need;
    logic        xflag;
    logic [7:0]  fb;
    logic [15:0] seq;
    logic [15:0] ext;
    logic [15:0] len;
    logic [15:0] lead;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The state starts at highest sequence 0, ROC 0, empty window.
    // Too short for the fixed header, at zero and one byte below twelve.
    send_packet(8'h80, 16'd0, 16'd0, 16'd0);
    send_packet(8'h80, 16'd0, 16'd0, 16'd11);
    // Every wrong version, the last one with all fields at their maximum.
    send_packet(8'h00, 16'd0, 16'd0, 16'd100);
    send_packet(8'h40, 16'd0, 16'd0, 16'd100);
    send_packet(8'hC0, 16'd0, 16'd0, 16'd100);
    send_packet(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Fifteen CSRCs with an extension: one byte short of the extension header,
    // then exactly long enough (sequence 0 equals the highest, its bit is clear).
    send_packet(8'h9F, 16'd0, 16'd0, 16'd75);
    send_packet(8'h9F, 16'd0, 16'd0, 16'd76);
    // Fifteen CSRCs without extension, one byte short.
    send_packet(8'h8F, 16'd1, 16'd0, 16'd71);
    // Extension length that pushes the payload past any possible length.
    send_packet(8'h90, 16'd1, 16'hFFFF, 16'hFFFF);
    // Replay of sequence 0.
    send_packet(8'h80, 16'd0, 16'd0, 16'd12);
    // Ahead by ten; the extension length must be ignored with the flag clear.
    send_packet(8'h80, 16'd10, 16'hFFFF, 16'd12);
    // Behind across the wrap, so the ROC estimate drops below zero, then its replay.
    send_packet(8'h80, 16'd65530, 16'd0, 16'd12);
    send_packet(8'h80, 16'd65530, 16'd0, 16'd12);
    send_packet(8'h80, 16'd9, 16'd0, 16'd12);
    // Exactly half the sequence space away: always rejected.
    send_packet(8'h80, 16'h800A, 16'd0, 16'd12);
    // Largest forward step, with a payload offset that fits a maximum-length packet.
    send_packet(8'h90, 16'h8009, 16'd16363, 16'hFFFF);
    send_packet(8'h80, 16'd10, 16'd0, 16'd12);
    send_packet(8'h80, 16'hFFFF, 16'd0, 16'd12);
    // Ahead across the wrap: the ROC estimate rises.
    send_packet(8'hBF, 16'd5, 16'd0, 16'hFFFF);
    // Oldest slot of the window, then one past it.
    send_packet(8'h80, 16'd65478, 16'd0, 16'd12);
    send_packet(8'h80, 16'd65477, 16'd0, 16'd12);
    // A jump of exactly the window size clears the bitmap.
    send_packet(8'h80, 16'd69, 16'd0, 16'd12);
    send_packet(8'h80, 16'd6, 16'd0, 16'd12);
    send_packet(8'hA0, 16'd5, 16'd0, 16'd12);

    // Random part. Most headers are well formed and follow a moving sequence
    // cursor with small steps, reordering and duplicates near the window edge,
    // and big jumps that cross the wrap; the rest is raw noise.
    lead = 16'd69;
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // Let the block drain completely before carrying on.
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
      end

      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        lead = lead + 16'($urandom_range(1, 4));
        seq  = lead;
      end else if (pick < 70) begin
        seq = lead - 16'($urandom_range(0, 80));
      end else if (pick < 75) begin
        seq = lead;
      end else if (pick < 83) begin
        lead = lead + 16'($urandom_range(60, 32767));
        seq  = lead;
      end else if (pick < 86) begin
        seq = lead + 16'h8000;
      end else if (pick < 90) begin
        seq  = 16'($urandom_range(0, 65535));
        lead = seq;
      end else begin
        lead = lead + 16'($urandom_range(100, 2000));
        seq  = lead;
      end

      if ($urandom_range(0, 99) < 85) begin
        cc    = $urandom_range(0, 15);
        xflag = ($urandom_range(0, 99) < 30);
        fb    = {2'b10, 1'($urandom_range(0, 1)), xflag, 4'(cc)};
        if (xflag) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      ext = 16'($urandom_range(0, 16));
          else if (pick < 90) ext = 16'($urandom_range(0, 1000));
          else                ext = 16'($urandom_range(0, 65535));
          need = srtp_pkg::HDR_FIXED_LEN + 4 * cc + srtp_pkg::EXT_HDR_LEN + 4 * int'(ext);
        end else begin
          ext  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
          need = srtp_pkg::HDR_FIXED_LEN + 4 * cc;
        end
        pick = $urandom_range(0, 99);
        if (need > 65535)      len = 16'($urandom_range(0, 65535));
        else if (pick < 8)     len = 16'(need - 1);
        else if (pick < 12)    len = 16'hFFFF;
        else if (need + 300 > 65535) len = 16'hFFFF - 16'($urandom_range(0, 65535 - need));
        else                   len = 16'(need + $urandom_range(0, 300));
      end else begin
        fb  = 8'($urandom_range(0, 255));
        ext = 16'($urandom_range(0, 65535));
        len = 16'($urandom_range(0, 65535));
      end
      send_packet(fb, seq, ext, len);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    // The watchdog ends the run if results stop arriving here.
    while (n_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_mismatch == 0 && n_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/srtp_pkg.sv
rtl/core/srtp_hdr_chk.sv
rtl/core/srtp_replay.sv
rtl/core/srtp_rtp_replay_and_roc_check.sv
dv/srtp_replay_checker.sv
dv/tb_srtp_rtp_replay_and_roc_check.sv
